[hw/rtl/raw_two_wire_bit_master_top_macros.svh]
// Assertion macros used by the two-wire bit master checker.
`ifndef RAW_TWO_WIRE_BIT_MASTER_TOP_MACROS_SVH
`define RAW_TWO_WIRE_BIT_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RTBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RTBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/rtbm_pkg.sv]
// Types and constants of the raw two-wire bit master.
package rtbm_pkg;

   localparam int unsigned MAX_BITS    = 32;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BITS_W      = 6;
   localparam int unsigned BIT_IDX_W   = 5;
   localparam int unsigned WAIT_W      = 17;
   localparam int unsigned HALF_W      = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd500;
   localparam logic [BITS_W-1:0] BIT_COUNT_RESET   = 6'd8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [1:0] CSR_BIT_COUNT   = 2'd1;
   localparam logic [1:0] CSR_OPEN_DRAIN  = 2'd2;

   // Highest request code that means something.
   localparam logic [3:0] REQ_LAST = 4'd11;

   // Step phases of a timed sequence.
   localparam logic [1:0] PH_SETUP = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_TAIL  = 2'd2;

   typedef enum logic [3:0] {
      CMD_TICK    = 4'd0,
      CMD_START   = 4'd1,
      CMD_STOP    = 4'd2,
      CMD_WRITE   = 4'd3,
      CMD_READ    = 4'd4,
      CMD_CLKHI   = 4'd5,
      CMD_CLKLO   = 4'd6,
      CMD_DATHI   = 4'd7,
      CMD_DATLO   = 4'd8,
      CMD_SAMPLE  = 4'd9,
      CMD_PULSE   = 4'd10,
      CMD_BITREAD = 4'd11,
      CMD_IGNORE  = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_STOP,
      SEQ_WRITE,
      SEQ_READ,
      SEQ_PULSE,
      SEQ_BITREAD
   } seq_type;

   typedef struct packed {
      logic [3:0]        req_type;
      logic [WORD_W-1:0] write_word;
      logic              line_level;
   } req_item_type;

   typedef struct packed {
      logic              clock_level;
      logic              data_level;
      logic              data_enable;
      logic              busy_res;
      logic [WORD_W-1:0] read_word;
      logic              read_valid;
      logic              cmd_rejected;
   } rsp_item_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [WORD_W-1:0] word;
      logic              lvl;
   } cmd_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

[hw/rtl/raw_two_wire_bit_master_top.sv]
// Raw two-wire bit master: takes one request per clock while the queue is not
// full (a microsecond tick or a bus command) and returns one response per
// request showing the clock and data line drive, busy flag, read result and
// rejection flag after that request. Requests pass through a four-entry queue
// and the response register; the sustained rate is one request per cycle while
// responses are taken, limited by the engine's single state update per cycle.
// The engine takes the next request in the same cycle that a waiting response
// is taken. Configuration writes are accepted in any cycle and must be made
// only while no request is outstanding.
module raw_two_wire_bit_master_top
   import rtbm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_item_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [HALF_W-1:0] csr_wdata
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_item_type     push_item;
   cmd_item_type     head_item;

   rtbm_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   rtbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   rtbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/rtbm_front.sv]
// Request front end: classifies each request and pushes it into the queue.
module rtbm_front
   import rtbm_pkg::*;
(
   input  logic             req_valid,
   output logic             req_ready,
   input  req_item_type     req_data,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_item_type     push_item
);

   always_comb begin
      push_item.word = req_data.write_word;
      push_item.lvl  = req_data.line_level;
      if (req_data.req_type <= REQ_LAST) begin
         push_item.cmd = cmd_type'(req_data.req_type);
      end else begin
         push_item.cmd = CMD_IGNORE;
      end
   end

   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

endmodule

[hw/rtl/rtbm_queue.sv]
// Short queue of classified requests between the front end and the engine.
module rtbm_queue
   import rtbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_item_type     push_item,
   input  logic             pop,
   output cmd_item_type     head_item,
   output queue_status_type q_status
);

   cmd_item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = slot_ff[rd_ptr_ff];
   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

[hw/rtl/rtbm_back.sv]
// Bus engine: configuration registers, waveform sequencer and response register.
module rtbm_back
   import rtbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [HALF_W-1:0] csr_wdata,
   input  queue_status_type q_status,
   input  cmd_item_type     head_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_item_type     rsp_data
);

   logic [HALF_W-1:0]    half_period_ff;
   logic [BITS_W-1:0]    bit_count_ff;
   logic                 open_drain_ff;

   seq_type              active_ff, active_in;
   logic [1:0]           phase_ff, phase_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [BITS_W-1:0]    bits_ff, bits_in;
   logic [WORD_W-1:0]    shift_ff, shift_in;
   logic                 clk_ff, clk_in;
   logic                 dat_ff, dat_in;
   logic                 drv_ff, drv_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;

   logic [WAIT_W-1:0]    half_wait;
   logic [WAIT_W-1:0]    full_wait;
   logic [BITS_W-1:0]    n_bits;
   logic [BITS_W-1:0]    n_m1;
   logic [BITS_W-1:0]    bits_dec;
   logic [BITS_W-1:0]    bits_dec_m1;
   logic [WORD_W-1:0]    shift_next;
   logic [WORD_W-1:0]    rd_word;
   logic                 rd_valid;
   logic                 rejected;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         bit_count_ff   <= BIT_COUNT_RESET;
         open_drain_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            CSR_BIT_COUNT:   bit_count_ff   <= csr_wdata[BITS_W-1:0];
            CSR_OPEN_DRAIN:  open_drain_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign half_wait = WAIT_W'(half_period_ff);
   assign full_wait = WAIT_W'({half_period_ff, 1'b0});
   assign n_bits    = (bit_count_ff > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : bit_count_ff;
   assign n_m1      = n_bits - 1'b1;

   // A new request is taken when the response register is free or being emptied.
   assign pop = q_status.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      active_in   = active_ff;
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      clk_in      = clk_ff;
      dat_in      = dat_ff;
      drv_in      = drv_ff;
      rd_word     = '0;
      rd_valid    = 1'b0;
      rejected    = 1'b0;
      bits_dec    = (bits_ff != '0) ? bits_ff - 1'b1 : bits_ff;
      bits_dec_m1 = bits_dec - 1'b1;
      shift_next  = (active_ff == SEQ_READ) ? {shift_ff[WORD_W-2:0], head_item.lvl}
                                            : shift_ff;

      if (pop) begin
         case (head_item.cmd)
            CMD_TICK: begin
               if (active_ff != SEQ_IDLE) begin
                  if (wait_ff > WAIT_W'(1)) begin
                     wait_in = wait_ff - 1'b1;
                  end else begin
                     case (active_ff)
                        SEQ_START: begin
                           if (phase_ff == PH_SETUP) begin
                              dat_in   = 1'b0;
                              phase_in = PH_HIGH;
                              wait_in  = half_wait;
                           end else begin
                              clk_in    = 1'b0;
                              dat_in    = 1'b0;
                              active_in = SEQ_IDLE;
                              phase_in  = PH_SETUP;
                              wait_in   = '0;
                           end
                        end
                        SEQ_STOP: begin
                           if (phase_ff == PH_SETUP) begin
                              dat_in   = 1'b1;
                              phase_in = PH_HIGH;
                              wait_in  = half_wait;
                           end else begin
                              active_in = SEQ_IDLE;
                              phase_in  = PH_SETUP;
                              wait_in   = '0;
                           end
                        end
                        SEQ_WRITE, SEQ_READ: begin
                           if (phase_ff == PH_SETUP) begin
                              clk_in   = 1'b1;
                              phase_in = PH_HIGH;
                              wait_in  = half_wait;
                           end else begin
                              shift_in = shift_next;
                              clk_in   = 1'b0;
                              bits_in  = bits_dec;
                              if (bits_dec != '0) begin
                                 if (active_ff == SEQ_WRITE) begin
                                    dat_in = shift_ff[bits_dec_m1[BIT_IDX_W-1:0]];
                                 end
                                 phase_in = PH_SETUP;
                                 wait_in  = half_wait;
                              end else begin
                                 if (active_ff == SEQ_READ) begin
                                    rd_valid = 1'b1;
                                    rd_word  = shift_next;
                                 end
                                 active_in = SEQ_IDLE;
                                 phase_in  = PH_SETUP;
                                 wait_in   = '0;
                              end
                           end
                        end
                        SEQ_PULSE, SEQ_BITREAD: begin
                           if (phase_ff == PH_SETUP) begin
                              clk_in   = 1'b1;
                              phase_in = PH_HIGH;
                              wait_in  = half_wait;
                           end else if (phase_ff == PH_HIGH) begin
                              // The bit is taken on the falling clock edge.
                              if (active_ff == SEQ_BITREAD) begin
                                 shift_in = WORD_W'(head_item.lvl);
                              end
                              clk_in   = 1'b0;
                              phase_in = PH_TAIL;
                              wait_in  = full_wait;
                           end else begin
                              if (active_ff == SEQ_BITREAD) begin
                                 rd_valid = 1'b1;
                                 rd_word  = WORD_W'(shift_ff[0]);
                              end
                              active_in = SEQ_IDLE;
                              phase_in  = PH_SETUP;
                              wait_in   = '0;
                           end
                        end
                        default: begin
                           active_in = SEQ_IDLE;
                           phase_in  = PH_SETUP;
                           wait_in   = '0;
                        end
                     endcase
                  end
               end
            end
            CMD_IGNORE: ;
            default: begin
               if (active_ff != SEQ_IDLE) begin
                  rejected = 1'b1;
               end else begin
                  case (head_item.cmd)
                     CMD_START: begin
                        drv_in    = 1'b1;
                        dat_in    = 1'b1;
                        clk_in    = 1'b1;
                        active_in = SEQ_START;
                        phase_in  = PH_SETUP;
                        wait_in   = half_wait;
                     end
                     CMD_STOP: begin
                        drv_in    = 1'b1;
                        dat_in    = 1'b0;
                        clk_in    = 1'b1;
                        active_in = SEQ_STOP;
                        phase_in  = PH_SETUP;
                        wait_in   = half_wait;
                     end
                     CMD_WRITE: begin
                        drv_in   = 1'b1;
                        clk_in   = 1'b0;
                        shift_in = head_item.word;
                        bits_in  = n_bits;
                        if (n_bits != '0) begin
                           dat_in    = head_item.word[n_m1[BIT_IDX_W-1:0]];
                           active_in = SEQ_WRITE;
                           phase_in  = PH_SETUP;
                           wait_in   = half_wait;
                        end
                     end
                     CMD_READ: begin
                        drv_in   = 1'b0;
                        shift_in = '0;
                        bits_in  = n_bits;
                        if (n_bits == '0) begin
                           rd_valid = 1'b1;
                        end else begin
                           active_in = SEQ_READ;
                           phase_in  = PH_SETUP;
                           wait_in   = half_wait;
                        end
                     end
                     CMD_CLKHI: clk_in = 1'b1;
                     CMD_CLKLO: clk_in = 1'b0;
                     CMD_DATHI: begin
                        drv_in = 1'b1;
                        dat_in = 1'b1;
                     end
                     CMD_DATLO: begin
                        drv_in = 1'b1;
                        dat_in = 1'b0;
                     end
                     CMD_SAMPLE: begin
                        drv_in   = 1'b0;
                        rd_valid = 1'b1;
                        rd_word  = WORD_W'(head_item.lvl);
                     end
                     CMD_PULSE: begin
                        active_in = SEQ_PULSE;
                        phase_in  = PH_SETUP;
                        wait_in   = full_wait;
                     end
                     CMD_BITREAD: begin
                        drv_in    = 1'b0;
                        active_in = SEQ_BITREAD;
                        phase_in  = PH_SETUP;
                        wait_in   = full_wait;
                     end
                     default: ;
                  endcase
               end
            end
         endcase
      end

      rsp_data_in.clock_level  = clk_in;
      rsp_data_in.data_level   = dat_in;
      rsp_data_in.data_enable  = drv_in && !(open_drain_ff && dat_in);
      rsp_data_in.busy_res     = (active_in != SEQ_IDLE);
      rsp_data_in.read_word    = rd_word;
      rsp_data_in.read_valid   = rd_valid;
      rsp_data_in.cmd_rejected = rejected;

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= SEQ_IDLE;
         phase_ff     <= PH_SETUP;
         wait_ff      <= '0;
         bits_ff      <= '0;
         shift_ff     <= '0;
         clk_ff       <= 1'b0;
         dat_ff       <= 1'b1;
         drv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
         clk_ff       <= clk_in;
         dat_ff       <= dat_in;
         drv_ff       <= drv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/rtbm_checker.sv]
// Port-level checks of the two-wire bit master, bound to the top level.
`include "raw_two_wire_bit_master_top_macros.svh"

module rtbm_checker
   import rtbm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   `RTBM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

   `RTBM_ASSERT_NOW(a_read_word_zero, rsp_valid && !rsp_data.read_valid, rsp_data.read_word == '0, "read word set without a completed read")

   `RTBM_ASSERT_NOW(a_reject_busy, rsp_valid && rsp_data.cmd_rejected, rsp_data.busy_res, "request rejected while not busy")

   `RTBM_ASSERT_NOW(a_read_done_idle, rsp_valid && rsp_data.read_valid, !rsp_data.busy_res && !rsp_data.cmd_rejected, "read completed while still busy")

endmodule

bind raw_two_wire_bit_master_top rtbm_checker u_checker (.*);
